// ===== sv/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

    localparam int unsigned GRANULE_SHIFT = 3;
    localparam logic [16:0] GRANULE_ROUND = 17'h7;
    localparam logic        MODE_FREE     = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_bytes;
        logic [11:0] block_address;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [11:0] payload_address;
    } resp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_TOP,
        ST_A_CHK,
        ST_A_W1,
        ST_A_W2,
        ST_A_W3,
        ST_F_START,
        ST_F_HDR,
        ST_F_TOP,
        ST_F_CHK,
        ST_F_W1,
        ST_F_W2,
        ST_FAIL,
        ST_DONE_A,
        ST_DONE_F
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_RD_CUR,
        DP_ADV,
        DP_A_W1,
        DP_A_W2,
        DP_A_W3,
        DP_F_RD,
        DP_F_HDR,
        DP_F_RDN,
        DP_F_MERGE,
        DP_F_W1,
        DP_F_W2,
        DP_RES_FAIL,
        DP_RES_ALLOC,
        DP_RES_FREE
    } dp_op_t;

    typedef struct packed {
        logic in_free;
        logic zero_req;
        logic free_bad;
        logic live_ok;
        logic size_ok;
        logic fit;
        logic merge_go;
        logic n_mergeable;
    } dp_status_t;

endpackage

// ===== sv/ffha_dp.sv =====
// Datapath: header memories, free-list pointers, walk registers, result register.
module ffha_dp
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_UNITS   = 4096,
    parameter int unsigned HEADER_UNITS = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    input  dp_op_t     op,
    output dp_status_t status,
    output resp_t      rsp
);

    localparam int unsigned AW = $clog2(HEAP_UNITS);
    localparam int unsigned XW = ((AW > 16) ? AW : 16) + 2;
    localparam int unsigned SW = $clog2(HEAP_UNITS + 2);
    localparam logic [AW-1:0] END_MARK = AW'(HEAP_UNITS - HEADER_UNITS);
    localparam logic [XW-1:0] HDR_X    = XW'(HEADER_UNITS);
    localparam logic [SW-1:0] HEAP_S   = SW'(HEAP_UNITS);
    localparam logic [AW:0]   HEAP_A   = (AW+1)'(HEAP_UNITS);

    typedef struct packed {
        logic [AW-1:0] next;
        logic          next_ok;
        logic          used;
    } link_t;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic          ok;
    } ptr_t;

    typedef struct packed {
        logic link0;
        logic linke;
        logic nf0;
        logic nfe;
        logic pf0;
        logic pfe;
        logic oor;
    } rd_fix_t;

    localparam link_t LINK_RST0 = '{next: END_MARK, next_ok: 1'b1, used: 1'b0};
    localparam ptr_t  NF_RST0   = '{addr: END_MARK, ok: 1'b1};
    localparam ptr_t  PF_RSTE   = '{addr: '0, ok: 1'b1};

    link_t link_mem [HEAP_UNITS];
    ptr_t  nf_mem   [HEAP_UNITS];
    ptr_t  pf_mem   [HEAP_UNITS];

    req_t          req_reg,       req_next;
    logic [13:0]   units_reg,     units_next;
    logic [AW-1:0] cur_reg,       cur_next;
    logic          live_reg,      live_next;
    logic [SW-1:0] steps_reg,     steps_next;
    logic [AW-1:0] fnext_reg,     fnext_next;
    logic          fnext_ok_reg,  fnext_ok_next;
    ptr_t          head_reg,      head_next;
    resp_t         rsp_reg,       rsp_next;
    logic [5:0]    ovr_reg,       ovr_next;

    link_t   rd_link_reg;
    ptr_t    rd_nf_reg;
    ptr_t    rd_pf_reg;
    rd_fix_t rd_fix_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          link_we, nf_we, pf_we;
    logic [AW-1:0] link_wa, nf_wa, pf_wa;
    link_t         link_wd;
    ptr_t          nf_wd, pf_wd;

    link_t         hl;
    ptr_t          hn, hp, nf_sel;
    logic [16:0]   bytes_up;
    logic [13:0]   units_in;
    logic [XW-1:0] cur_hdr, next_x, sz, nb_x, pay_x, fl_x;
    logic [AW-1:0] nb;
    logic          split;

    // effective header of the last read; reset entries stand in until written
    always_comb
    begin
        hl = rd_link_reg;
        hn = rd_nf_reg;
        hp = rd_pf_reg;
        if (rd_fix_reg.link0)
        begin
            hl = LINK_RST0;
        end
        if (rd_fix_reg.linke)
        begin
            hl = '0;
        end
        if (rd_fix_reg.nf0)
        begin
            hn = NF_RST0;
        end
        if (rd_fix_reg.nfe)
        begin
            hn = '0;
        end
        if (rd_fix_reg.pf0)
        begin
            hp = '0;
        end
        if (rd_fix_reg.pfe)
        begin
            hp = PF_RSTE;
        end
        if (rd_fix_reg.oor)
        begin
            hl = '0;
            hn = '0;
            hp = '0;
        end
    end

    always_comb
    begin
        bytes_up = {1'b0, req.request_bytes} + GRANULE_ROUND;
        units_in = 14'(bytes_up >> GRANULE_SHIFT);
        cur_hdr  = XW'(cur_reg) + HDR_X;
        next_x   = XW'(hl.next);
        sz       = next_x - cur_hdr;
        nb_x     = cur_hdr + XW'(units_reg);
        nb       = nb_x[AW-1:0];
        split    = (XW'(units_reg) + HDR_X) < sz;
        nf_sel   = split ? ptr_t'{addr: nb, ok: 1'b1} : hn;
        pay_x    = XW'(req_reg.block_address);
        fl_x     = pay_x - HDR_X;
    end

    always_comb
    begin
        status.in_free     = (req.mode == MODE_FREE);
        status.zero_req    = (req_reg.request_bytes == 16'd0);
        status.free_bad    = (pay_x < HDR_X) || (fl_x >= XW'(END_MARK));
        status.live_ok     = live_reg && (steps_reg <= HEAP_S);
        status.size_ok     = hl.next_ok && (next_x >= cur_hdr);
        status.fit         = sz >= XW'(units_reg);
        status.merge_go    = fnext_ok_reg && (steps_reg < HEAP_S);
        status.n_mergeable = hl.next_ok && !hl.used;
    end

    always_comb
    begin
        req_next      = req_reg;
        units_next    = units_reg;
        cur_next      = cur_reg;
        live_next     = live_reg;
        steps_next    = steps_reg;
        fnext_next    = fnext_reg;
        fnext_ok_next = fnext_ok_reg;
        head_next     = head_reg;
        rsp_next      = rsp_reg;
        rd_en         = 1'b0;
        rd_addr       = cur_reg;
        link_we       = 1'b0;
        nf_we         = 1'b0;
        pf_we         = 1'b0;
        link_wa       = cur_reg;
        nf_wa         = cur_reg;
        pf_wa         = cur_reg;
        link_wd       = '0;
        nf_wd         = '0;
        pf_wd         = '0;
        case (op)
            DP_LOAD:
            begin
                req_next   = req;
                units_next = units_in;
                cur_next   = head_reg.addr;
                live_next  = head_reg.ok;
                steps_next = '0;
            end
            DP_RD_CUR:
            begin
                rd_en = 1'b1;
            end
            DP_ADV:
            begin
                cur_next   = hn.addr;
                live_next  = hn.ok;
                steps_next = steps_reg + 1'b1;
            end
            DP_A_W1:
            begin
                // split: new free block takes the tail of the found one
                link_we = split;
                link_wa = nb;
                link_wd = '{next: hl.next, next_ok: hl.next_ok, used: 1'b0};
                nf_we   = split;
                nf_wa   = nb;
                nf_wd   = hn;
                pf_we   = split && hn.ok;
                pf_wa   = hn.addr;
                pf_wd   = '{addr: nb, ok: 1'b1};
            end
            DP_A_W2:
            begin
                link_we = 1'b1;
                link_wd = '{next: split ? nb : hl.next,
                            next_ok: split || hl.next_ok, used: 1'b1};
                nf_we   = 1'b1;
                pf_we   = 1'b1;
            end
            DP_A_W3:
            begin
                pf_we = nf_sel.ok;
                pf_wa = nf_sel.addr;
                if (hp.ok)
                begin
                    nf_we = 1'b1;
                    nf_wa = hp.addr;
                    nf_wd = nf_sel;
                    pf_wd = '{addr: hp.addr, ok: 1'b1};
                end
                else
                begin
                    head_next = nf_sel;
                end
            end
            DP_F_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = fl_x[AW-1:0];
                cur_next   = fl_x[AW-1:0];
                steps_next = '0;
            end
            DP_F_HDR:
            begin
                fnext_next    = hl.next;
                fnext_ok_next = hl.next_ok;
            end
            DP_F_RDN:
            begin
                rd_en   = 1'b1;
                rd_addr = fnext_reg;
            end
            DP_F_MERGE:
            begin
                // unlink the following free block, absorb it
                if (hp.ok)
                begin
                    nf_we = 1'b1;
                    nf_wa = hp.addr;
                    nf_wd = hn;
                end
                else
                begin
                    head_next = hn;
                end
                pf_we         = hn.ok;
                pf_wa         = hn.addr;
                pf_wd         = hp;
                fnext_next    = hl.next;
                fnext_ok_next = hl.next_ok;
                steps_next    = steps_reg + 1'b1;
            end
            DP_F_W1:
            begin
                link_we = 1'b1;
                link_wd = '{next: fnext_reg, next_ok: fnext_ok_reg, used: 1'b0};
                nf_we   = 1'b1;
                nf_wd   = head_reg;
                pf_we   = 1'b1;
            end
            DP_F_W2:
            begin
                pf_we     = head_reg.ok;
                pf_wa     = head_reg.addr;
                pf_wd     = '{addr: cur_reg, ok: 1'b1};
                head_next = '{addr: cur_reg, ok: 1'b1};
            end
            DP_RES_FAIL:
            begin
                rsp_next = '0;
            end
            DP_RES_ALLOC:
            begin
                rsp_next = '{ok: 1'b1, payload_address: cur_hdr[11:0]};
            end
            DP_RES_FREE:
            begin
                rsp_next = '{ok: 1'b1, payload_address: 12'd0};
            end
            default:
            begin
            end
        endcase
        link_we = link_we && ({1'b0, link_wa} < HEAP_A);
        nf_we   = nf_we && ({1'b0, nf_wa} < HEAP_A);
        pf_we   = pf_we && ({1'b0, pf_wa} < HEAP_A);
    end

    // override order: link0, linke, nf0, nfe, pf0, pfe
    always_comb
    begin
        ovr_next = ovr_reg;
        if (link_we && link_wa == '0)
        begin
            ovr_next[5] = 1'b0;
        end
        if (link_we && link_wa == END_MARK)
        begin
            ovr_next[4] = 1'b0;
        end
        if (nf_we && nf_wa == '0)
        begin
            ovr_next[3] = 1'b0;
        end
        if (nf_we && nf_wa == END_MARK)
        begin
            ovr_next[2] = 1'b0;
        end
        if (pf_we && pf_wa == '0)
        begin
            ovr_next[1] = 1'b0;
        end
        if (pf_we && pf_wa == END_MARK)
        begin
            ovr_next[0] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '{addr: '0, ok: 1'b1};
            ovr_reg  <= '1;
        end
        else
        begin
            head_reg <= head_next;
            ovr_reg  <= ovr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        units_reg    <= units_next;
        cur_reg      <= cur_next;
        live_reg     <= live_next;
        steps_reg    <= steps_next;
        fnext_reg    <= fnext_next;
        fnext_ok_reg <= fnext_ok_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (nf_we)
        begin
            nf_mem[nf_wa] <= nf_wd;
        end
        if (pf_we)
        begin
            pf_mem[pf_wa] <= pf_wd;
        end
        if (rd_en)
        begin
            rd_link_reg      <= link_mem[rd_addr];
            rd_nf_reg        <= nf_mem[rd_addr];
            rd_pf_reg        <= pf_mem[rd_addr];
            rd_fix_reg.link0 <= ovr_reg[5] && (rd_addr == '0);
            rd_fix_reg.linke <= ovr_reg[4] && (rd_addr == END_MARK);
            rd_fix_reg.nf0   <= ovr_reg[3] && (rd_addr == '0);
            rd_fix_reg.nfe   <= ovr_reg[2] && (rd_addr == END_MARK);
            rd_fix_reg.pf0   <= ovr_reg[1] && (rd_addr == '0);
            rd_fix_reg.pfe   <= ovr_reg[0] && (rd_addr == END_MARK);
            rd_fix_reg.oor   <= !({1'b0, rd_addr} < HEAP_A);
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== sv/ffha_ctrl.sv =====
// Controller: sequences allocate walks, splits, free merges and the result beat.
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  dp_status_t status,
    output dp_op_t     op
);

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        slot_free      = !(rsp_valid_reg && rsp_stall);
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        op             = DP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op         = DP_LOAD;
                    state_next = status.in_free ? ST_F_START : ST_A_TOP;
                end
            end
            ST_A_TOP:
            begin
                if (status.zero_req || !status.live_ok)
                begin
                    state_next = ST_FAIL;
                end
                else
                begin
                    op         = DP_RD_CUR;
                    state_next = ST_A_CHK;
                end
            end
            ST_A_CHK:
            begin
                if (!status.size_ok)
                begin
                    state_next = ST_FAIL;
                end
                else if (status.fit)
                begin
                    state_next = ST_A_W1;
                end
                else
                begin
                    op         = DP_ADV;
                    state_next = ST_A_TOP;
                end
            end
            ST_A_W1:
            begin
                op         = DP_A_W1;
                state_next = ST_A_W2;
            end
            ST_A_W2:
            begin
                op         = DP_A_W2;
                state_next = ST_A_W3;
            end
            ST_A_W3:
            begin
                op         = DP_A_W3;
                state_next = ST_DONE_A;
            end
            ST_F_START:
            begin
                if (status.free_bad)
                begin
                    state_next = ST_FAIL;
                end
                else
                begin
                    op         = DP_F_RD;
                    state_next = ST_F_HDR;
                end
            end
            ST_F_HDR:
            begin
                op         = DP_F_HDR;
                state_next = ST_F_TOP;
            end
            ST_F_TOP:
            begin
                if (status.merge_go)
                begin
                    op         = DP_F_RDN;
                    state_next = ST_F_CHK;
                end
                else
                begin
                    state_next = ST_F_W1;
                end
            end
            ST_F_CHK:
            begin
                if (status.n_mergeable)
                begin
                    op         = DP_F_MERGE;
                    state_next = ST_F_TOP;
                end
                else
                begin
                    state_next = ST_F_W1;
                end
            end
            ST_F_W1:
            begin
                op         = DP_F_W1;
                state_next = ST_F_W2;
            end
            ST_F_W2:
            begin
                op         = DP_F_W2;
                state_next = ST_DONE_F;
            end
            ST_FAIL, ST_DONE_A, ST_DONE_F:
            begin
                // hold until the result register is free
                if (slot_free)
                begin
                    if (state_reg == ST_FAIL)
                    begin
                        op = DP_RES_FAIL;
                    end
                    else if (state_reg == ST_DONE_A)
                    begin
                        op = DP_RES_ALLOC;
                    end
                    else
                    begin
                        op = DP_RES_FREE;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== sv/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator.
//
// Request channel (req_valid / req_stall / req): one beat is an allocate
// (mode 0, request_bytes) or a free (mode 1, block_address). Response channel
// (rsp_valid / rsp_stall / rsp): exactly one beat per request, in order.
// One request is in flight at a time; req_stall is low only when idle.
// Allocate walks the free list entry by entry; free merges the following
// free blocks one by one. The pace is set by the single read port of the
// header memories: each list step or merge step is one registered read
// and one decision.
// The response sits in an output register; while the receiver stalls, the
// beat holds and the block can already take the next request, finishing
// it up to the point where its result waits for the register to empty.
// Reset (rst_n low, asynchronous) sets the heap to one free block from
// granule 0 up to the end marker; no clearing pass is needed, the block
// takes requests in the first cycle after reset.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_UNITS   = 4096,
    parameter int unsigned HEADER_UNITS = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output resp_t rsp
);

    dp_status_t status;
    dp_op_t     op;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .op        (op)
    );

    ffha_dp #(
        .HEAP_UNITS   (HEAP_UNITS),
        .HEADER_UNITS (HEADER_UNITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .op     (op),
        .status (status),
        .rsp    (rsp)
    );

endmodule

// ===== sv/ffha_check.sv =====
// Port-level checks for the allocator, bound to the top level.
module ffha_check
    import ffha_pkg::*;
#(
    parameter int unsigned HEADER_UNITS = 4
)
(
    input logic  clk,
    input logic  rst_n,
    input logic  req_valid,
    input logic  req_stall,
    input req_t  req,
    input logic  rsp_valid,
    input logic  rsp_stall,
    input resp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another is in flight");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.payload_address == 12'd0)
        else $error("failed response carries an address");

    a_above_header: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.ok && rsp.payload_address != 12'd0
            |-> rsp.payload_address >= 12'(HEADER_UNITS))
        else $error("payload address inside a header");

endmodule

bind first_fit_heap_allocator ffha_check #(.HEADER_UNITS(HEADER_UNITS)) u_ffha_check (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the first-fit heap allocator.
`timescale 1ns / 100ps

module testbench;
    import ffha_pkg::*;

    localparam int HEAP = 4096;
    localparam int HDR = 4;
    localparam int END_MARK = HEAP - HDR;
    localparam logic MODE_ALLOC = 1'b0;
    localparam int CYCLE_LIMIT = 40000000;

    typedef struct {
        int  nxt, nfree, pfree;
        bit  nxt_ok, nf_ok, pf_ok, used;
    } hdr_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    resp_t rsp;

    hdr_t  heap_hdr [HEAP];
    int    head;
    bit    head_ok;
    resp_t expected_rsp [$];
    int    live_blocks [$];
    int    errors = 0;
    int    cycles = 0;
    int    rsp_count = 0;
    int    alloc_hits = 0;
    int    merge_steps = 0;

    first_fit_heap_allocator u_dut (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL first_fit_heap_allocator");
            $finish;
        end
    end

    function automatic void heap_reset();
        foreach (heap_hdr[i]) heap_hdr[i] = '{0, 0, 0, 0, 0, 0, 0};
        heap_hdr[0].nxt = END_MARK;
        heap_hdr[0].nxt_ok = 1;
        heap_hdr[0].nfree = END_MARK;
        heap_hdr[0].nf_ok = 1;
        heap_hdr[END_MARK].pf_ok = 1;
        head = 0;
        head_ok = 1;
    endfunction

    function automatic resp_t alloc_predict(int bytes);
        int units, cur, sz, nf, steps, nb, pf;
        bit live, found, nf_ok;
        resp_t r;
        r = '0;
        if (bytes == 0) return r;
        units = (bytes + 7) >> 3;
        cur = head;
        live = head_ok;
        steps = 0;
        found = 0;
        while (live && steps <= HEAP)
        begin
            if (cur >= HEAP || !heap_hdr[cur].nxt_ok || heap_hdr[cur].nxt < cur + HDR)
                break;
            sz = heap_hdr[cur].nxt - cur - HDR;
            if (sz >= units)
            begin
                found = 1;
                break;
            end
            live = heap_hdr[cur].nf_ok;
            cur = heap_hdr[cur].nfree;
            steps++;
        end
        if (!found) return r;
        if (units + HDR < sz)
        begin
            nb = cur + HDR + units;
            heap_hdr[nb].nxt = heap_hdr[cur].nxt;
            heap_hdr[nb].nxt_ok = heap_hdr[cur].nxt_ok;
            heap_hdr[nb].used = 0;
            heap_hdr[nb].nfree = heap_hdr[cur].nfree;
            heap_hdr[nb].nf_ok = heap_hdr[cur].nf_ok;
            if (heap_hdr[cur].nf_ok)
            begin
                heap_hdr[heap_hdr[cur].nfree].pfree = nb;
                heap_hdr[heap_hdr[cur].nfree].pf_ok = 1;
            end
            heap_hdr[cur].nxt = nb;
            heap_hdr[cur].nxt_ok = 1;
            nf = nb;
            nf_ok = 1;
        end
        else
        begin
            nf = heap_hdr[cur].nfree;
            nf_ok = heap_hdr[cur].nf_ok;
        end
        if (heap_hdr[cur].pf_ok)
        begin
            pf = heap_hdr[cur].pfree;
            heap_hdr[pf].nfree = nf;
            heap_hdr[pf].nf_ok = nf_ok;
            if (nf_ok)
            begin
                heap_hdr[nf].pfree = pf;
                heap_hdr[nf].pf_ok = 1;
            end
        end
        else
        begin
            head = nf;
            head_ok = nf_ok;
            if (nf_ok) heap_hdr[nf].pf_ok = 0;
        end
        heap_hdr[cur].nfree = 0;
        heap_hdr[cur].nf_ok = 0;
        heap_hdr[cur].pfree = 0;
        heap_hdr[cur].pf_ok = 0;
        heap_hdr[cur].used = 1;
        r.ok = 1'b1;
        r.payload_address = 12'(cur + HDR);
        alloc_hits++;
        return r;
    endfunction

    function automatic resp_t free_predict(int payload);
        int fl, nx, steps, pf, nf;
        bit pf_ok, nf_ok;
        resp_t r;
        r = '0;
        if (payload < HDR) return r;
        fl = payload - HDR;
        if (fl >= END_MARK) return r;
        heap_hdr[fl].used = 0;
        steps = 0;
        while (steps < HEAP && heap_hdr[fl].nxt_ok)
        begin
            nx = heap_hdr[fl].nxt;
            if (!heap_hdr[nx].nxt_ok || heap_hdr[nx].used) break;
            pf = heap_hdr[nx].pfree; pf_ok = heap_hdr[nx].pf_ok;
            nf = heap_hdr[nx].nfree; nf_ok = heap_hdr[nx].nf_ok;
            if (pf_ok)
            begin
                heap_hdr[pf].nfree = nf;
                heap_hdr[pf].nf_ok = nf_ok;
            end
            else
            begin
                head = nf;
                head_ok = nf_ok;
            end
            if (nf_ok)
            begin
                heap_hdr[nf].pfree = pf;
                heap_hdr[nf].pf_ok = pf_ok;
            end
            heap_hdr[fl].nxt = heap_hdr[nx].nxt;
            heap_hdr[fl].nxt_ok = heap_hdr[nx].nxt_ok;
            steps++;
            merge_steps++;
        end
        heap_hdr[fl].nfree = head;
        heap_hdr[fl].nf_ok = head_ok;
        heap_hdr[fl].pfree = 0;
        heap_hdr[fl].pf_ok = 0;
        if (head_ok)
        begin
            heap_hdr[head].pfree = fl;
            heap_hdr[head].pf_ok = 1;
        end
        head = fl;
        head_ok = 1;
        r.ok = 1'b1;
        return r;
    endfunction

    // drive one beat; the prediction is queued at acceptance. Valid stays up
    // after acceptance until the next beat replaces it or an idle gap drops it.
    task automatic send_request(input req_t beat);
        resp_t r;
        int waits;
        waits = $urandom_range(0, 9);
        if (waits != 0)
        begin
            req_valid <= 1'b0;
            repeat (waits) @(negedge clk);
        end
        req <= beat;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        if (beat.mode == MODE_FREE)
        begin
            r = free_predict(beat.block_address);
            for (int i = 0; i < live_blocks.size(); i++)
                if (live_blocks[i] == beat.block_address)
                begin
                    live_blocks.delete(i);
                    break;
                end
        end
        else
        begin
            r = alloc_predict(beat.request_bytes);
            if (r.ok) live_blocks.push_back(r.payload_address);
        end
        expected_rsp.push_back(r);
        @(negedge clk);
    endtask

    function automatic req_t mk(logic m, int bytes, int addr);
        req_t b;
        b.mode = m;
        b.request_bytes = 16'(bytes);
        b.block_address = 12'(addr);
        return b;
    endfunction

    // receiver: random stall per beat, stretches of none
    initial
    begin
        int waits;
        forever
        begin
            @(negedge clk);
            waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (waits != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (waits) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!rsp_valid);
        end
    end

    always @(posedge clk)
    begin
        resp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_count++;
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected response ok=%0d addr=%0d", rsp.ok, rsp.payload_address);
                errors++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, rsp.ok);
                    errors++;
                end
                if (rsp.payload_address !== want.payload_address)
                begin
                    $error("payload_address: expected %0d, got %0d",
                           want.payload_address, rsp.payload_address);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        req_t  beat;
        bit    typed;
        resp_t want;
    } vector_t;

    vector_t directed [] = '{
        '{mk(MODE_ALLOC, 0, 12'hFFF), 1, '{1'b0, 12'd0}},      // zero request
        '{mk(MODE_ALLOC, 1, 0), 1, '{1'b1, 12'd4}},            // first fit at bottom
        '{mk(MODE_FREE, 0, 0), 1, '{1'b0, 12'd0}},             // free below header
        '{mk(MODE_FREE, 0, 3), 1, '{1'b0, 12'd0}},
        '{mk(MODE_FREE, 0, 1), 1, '{1'b0, 12'd0}},
        '{mk(MODE_FREE, 0, END_MARK + HDR), 1, '{1'b0, 12'd0}}, // wraps to zero
        '{mk(MODE_ALLOC, 16'hFFFF, 0), 1, '{1'b0, 12'd0}},     // out of memory
        '{mk(MODE_ALLOC, 32768, 0), 1, '{1'b0, 12'd0}},
        '{mk(MODE_ALLOC, 8, 0), 0, '{1'b0, 12'd0}},
        '{mk(MODE_ALLOC, 9, 0), 0, '{1'b0, 12'd0}},
        '{mk(MODE_ALLOC, 40, 0), 0, '{1'b0, 12'd0}},
        '{mk(MODE_FREE, 0, 4), 1, '{1'b1, 12'd0}},
        '{mk(MODE_ALLOC, 8, 0), 0, '{1'b0, 12'd0}},
        '{mk(MODE_FREE, 0, 9), 0, '{1'b0, 12'd0}},             // following block in use, no merge
        '{mk(MODE_ALLOC, 32000, 0), 0, '{1'b0, 12'd0}},        // most of the heap
        '{mk(MODE_ALLOC, 200, 0), 0, '{1'b0, 12'd0}}
    };

    initial
    begin
        int n, bytes;
        heap_reset();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            send_request(directed[i].beat);
            // typed rows cross-check the predictor against the table
            if (directed[i].typed && expected_rsp[$] != directed[i].want)
            begin
                $error("ok/payload_address: expected %0d/%0d, predicted %0d/%0d",
                       directed[i].want.ok, directed[i].want.payload_address,
                       expected_rsp[$].ok, expected_rsp[$].payload_address);
                errors++;
            end
        end
        // free everything still held so the random part starts clean
        while (live_blocks.size() > 0)
            send_request(mk(MODE_FREE, $urandom, live_blocks[0]));

        n = 0;
        while (n < 1350)
        begin
            if (n == 600)
            begin
                req_valid <= 1'b0;
                wait (expected_rsp.size() == 0);
                @(negedge clk);
            end
            case ($urandom_range(0, 19))
                0: send_request(mk(MODE_FREE, $urandom, $urandom_range(0, HDR - 1)));
                1: send_request(mk(MODE_FREE, $urandom, END_MARK + HDR));
                2: send_request(mk(MODE_ALLOC, 0, $urandom));
                3: send_request(mk(MODE_ALLOC, $urandom_range(0, 16'hFFFF), $urandom));
                default:
                begin
                    if (live_blocks.size() > 0 &&
                        ($urandom_range(0, 1) == 0 || live_blocks.size() > 40))
                        send_request(mk(MODE_FREE, $urandom,
                            live_blocks[$urandom_range(0, live_blocks.size() - 1)]));
                    else
                    begin
                        bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16000)
                                                            : $urandom_range(1, 600);
                        send_request(mk(MODE_ALLOC, bytes, $urandom));
                    end
                end
            endcase
            n++;
        end

        req_valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (50) @(posedge clk);
        $display("Checked %0d responses: %0d successful allocations, %0d forward merges.",
                 rsp_count, alloc_hits, merge_steps);
        if (errors == 0)
            $display("PASS first_fit_heap_allocator");
        else
            $display("FAIL first_fit_heap_allocator");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ffha_pkg.sv
sv/ffha_dp.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator.sv
sv/ffha_check.sv
tb/testbench.sv
